// ----- sv/pps_pkg.sv -----
// Shared types, character codes and type-letter lookup for the printf spec parser.
`default_nettype none

package pps_pkg;

  localparam int NUMBER_BITS_DEFAULT = 16;
  localparam int FIELD_BITS = 16;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [3:0] {
    TYPE_C       = 4'd0,
    TYPE_S       = 4'd1,
    TYPE_P       = 4'd2,
    TYPE_D       = 4'd3,
    TYPE_I       = 4'd4,
    TYPE_U       = 4'd5,
    TYPE_X_LOWER = 4'd6,
    TYPE_X_UPPER = 4'd7,
    TYPE_PCT     = 4'd8
  } type_code_t;

  // Flags collected between the percent sign and the type letter; all but in_digits are sticky.
  typedef struct packed {
    logic alt;
    logic dot;
    logic minus;
    logic zero;
    logic plus;
    logic space;
    logic in_digits;
  } flags_t;

  // One resolved specifier, in output field order.
  typedef struct packed {
    logic [FIELD_BITS-1:0] precision_value;
    logic [FIELD_BITS-1:0] field_width;
    logic                  has_precision;
    logic                  space_sign;
    logic                  plus_sign;
    logic                  zero_pad;
    logic                  left_justify;
    logic                  alt_form;
    logic                  ended_early;
    type_code_t            type_code;
  } spec_t;

  typedef struct packed {
    logic       hit;
    type_code_t code;
  } type_match_t;

  function automatic type_match_t match_type(input logic [7:0] c);
    type_match_t m;
    m.hit  = 1'b1;
    m.code = TYPE_C;
    case (c)
      8'h63:   m.code = TYPE_C;
      8'h73:   m.code = TYPE_S;
      8'h70:   m.code = TYPE_P;
      8'h64:   m.code = TYPE_D;
      8'h69:   m.code = TYPE_I;
      8'h75:   m.code = TYPE_U;
      8'h78:   m.code = TYPE_X_LOWER;
      8'h58:   m.code = TYPE_X_UPPER;
      8'h25:   m.code = TYPE_PCT;
      default: m.hit  = 1'b0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/printf_spec_parser.sv -----
// Top level of the printf format specifier parser with stream handshakes.
//
// Usage: send the bytes that follow a percent sign on the slave channel, one
// byte per transfer in s_tdata. Flag, width and precision characters update
// internal state and produce nothing. A type letter from "cspdiuxX%" or a NUL
// byte produces one result transfer on the master channel carrying the
// resolved specifier, and the parser clears itself for the next specifier.
// Pipeline: a byte accepted at a clock edge is in the input register after
// that edge; its result, if any, is loaded from the input register into
// the output register, which drives m_tvalid, once that register is free.
// Throughput: one byte per cycle sustained. The only feedback path is the
// flag and accumulator update, a combinational multiply-by-ten add.
// When the receiver stalls, the result holds in the output register; bytes
// that produce no result keep flowing, and one byte that produces a result
// waits in the input register, holding s_tready low, until the output
// register frees up.
// Reset (rst, synchronous, active high) empties both registers and clears
// all flags and accumulators.
`default_nettype none

module printf_spec_parser #(
  parameter int NUMBER_BITS = pps_pkg::NUMBER_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] alt_form, [1] left_justify, [2] zero_pad, [3] plus_sign,
  // [4] space_sign, [5] has_precision, [21:6] field_width,
  // [37:22] precision_value, [39:38] zero
  output logic [39:0]      m_tdata,
  output logic [4:0]       m_tuser    // [3:0] type_code, [4] ended_early
);

  // Input register.
  logic       in_valid;
  logic [7:0] in_char;

  // Parser state.
  pps_pkg::flags_t        flags;
  logic [NUMBER_BITS-1:0] width_acc;
  logic [NUMBER_BITS-1:0] precision_acc;

  // Step outputs.
  pps_pkg::flags_t        flags_next;
  logic [NUMBER_BITS-1:0] width_acc_next;
  logic [NUMBER_BITS-1:0] precision_acc_next;
  logic                   emit;
  pps_pkg::spec_t         spec;

  // Result register.
  pps_pkg::spec_t         out_spec;
  logic                   consume;

  pps_step #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_step (
    .char_in           (in_char),
    .flags             (flags),
    .width_acc         (width_acc),
    .precision_acc     (precision_acc),
    .flags_next        (flags_next),
    .width_acc_next    (width_acc_next),
    .precision_acc_next(precision_acc_next),
    .emit              (emit),
    .spec              (spec)
  );

  // The held byte retires when it makes no result, or the result register is
  // empty or being emptied in this cycle.
  assign consume  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= '0;
      width_acc     <= '0;
      precision_acc <= '0;
    end else if (consume) begin
      flags         <= flags_next;
      width_acc     <= width_acc_next;
      precision_acc <= precision_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_spec <= spec;
    end
  end

  assign m_tuser = {out_spec.ended_early, out_spec.type_code};
  assign m_tdata = {2'b00,
                    out_spec.precision_value,
                    out_spec.field_width,
                    out_spec.has_precision,
                    out_spec.space_sign,
                    out_spec.plus_sign,
                    out_spec.zero_pad,
                    out_spec.left_justify,
                    out_spec.alt_form};

  // A result never appears in the cycle right after reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A specifier cut short by NUL always carries the first type code.
  a_early_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[4]) |-> (m_tuser[3:0] == pps_pkg::TYPE_C))
    else $error("ended-early result with nonzero type code");

  // Zero padding is resolved away by a dot or a minus flag.
  a_zero_resolved: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (!m_tdata[1] && !m_tdata[5]))
    else $error("zero pad reported together with minus or dot");

  // The space flag is resolved away by the plus flag.
  a_space_resolved: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
    else $error("space sign reported together with plus sign");

  // A byte that completes a specifier while the output is stalled must wait.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && emit && m_tvalid && !m_tready) |=> (in_valid && $stable(in_char)))
    else $error("terminating byte lost while the output was stalled");

endmodule

`default_nettype wire

// ----- sv/pps_step.sv -----
// Per-character step logic: flag updates, digit accumulation and spec resolution.
`default_nettype none

module pps_step #(
  parameter int NUMBER_BITS = pps_pkg::NUMBER_BITS_DEFAULT
) (
  input  wire logic [7:0]             char_in,
  input  wire pps_pkg::flags_t        flags,
  input  wire logic [NUMBER_BITS-1:0] width_acc,
  input  wire logic [NUMBER_BITS-1:0] precision_acc,
  output pps_pkg::flags_t             flags_next,
  output logic [NUMBER_BITS-1:0]      width_acc_next,
  output logic [NUMBER_BITS-1:0]      precision_acc_next,
  output logic                        emit,
  output pps_pkg::spec_t              spec
);

  localparam int WIDE_BITS = NUMBER_BITS + 4;

  pps_pkg::type_match_t  tm;
  logic                  is_nul;
  logic                  is_digit;
  logic                  digit_run;
  logic [3:0]            digit;
  logic [NUMBER_BITS-1:0] acc_sel;
  logic [WIDE_BITS-1:0]  acc_wide;
  logic [WIDE_BITS-1:0]  sum;
  logic [NUMBER_BITS-1:0] acc_new;
  logic [31:0]           width_ext;
  logic [31:0]           prec_ext;

  assign tm       = pps_pkg::match_type(char_in);
  assign is_nul   = (char_in == pps_pkg::CHAR_NUL);
  assign emit     = is_nul || tm.hit;
  assign is_digit = (char_in >= pps_pkg::CHAR_ZERO) && (char_in <= pps_pkg::CHAR_NINE);
  assign digit_run = is_digit && (flags.in_digits || (char_in != pps_pkg::CHAR_ZERO) ||
                                  flags.dot || flags.minus);
  assign digit    = 4'(char_in - pps_pkg::CHAR_ZERO);

  // acc*10 + digit as two shifted copies; saturate when any bit above the number width is set.
  assign acc_sel  = flags.dot ? precision_acc : width_acc;
  assign acc_wide = WIDE_BITS'(acc_sel);
  assign sum      = flags.in_digits ? ((acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit))
                                    : WIDE_BITS'(digit);
  assign acc_new  = (sum[WIDE_BITS-1:NUMBER_BITS] != '0) ? {NUMBER_BITS{1'b1}}
                                                        : sum[NUMBER_BITS-1:0];

  always_comb begin
    flags_next           = flags;
    flags_next.in_digits = 1'b0;
    width_acc_next       = width_acc;
    precision_acc_next   = precision_acc;
    if (emit) begin
      flags_next         = '0;
      width_acc_next     = '0;
      precision_acc_next = '0;
    end else if (digit_run) begin
      flags_next.in_digits = 1'b1;
      if (flags.dot) begin
        precision_acc_next = acc_new;
      end else begin
        width_acc_next = acc_new;
      end
    end else begin
      case (char_in)
        pps_pkg::CHAR_HASH:  flags_next.alt   = 1'b1;
        pps_pkg::CHAR_DOT:   flags_next.dot   = 1'b1;
        pps_pkg::CHAR_MINUS: flags_next.minus = 1'b1;
        pps_pkg::CHAR_ZERO:  flags_next.zero  = 1'b1;
        pps_pkg::CHAR_PLUS:  flags_next.plus  = 1'b1;
        pps_pkg::CHAR_SPACE: if (!flags.plus) flags_next.space = 1'b1;
        default:             flags_next.in_digits = 1'b0;
      endcase
    end
  end

  assign width_ext = 32'(width_acc);
  assign prec_ext  = 32'(precision_acc);

  always_comb begin
    spec.type_code       = is_nul ? pps_pkg::TYPE_C : tm.code;
    spec.ended_early     = is_nul;
    spec.alt_form        = flags.alt;
    spec.left_justify    = flags.minus;
    spec.zero_pad        = flags.zero && !flags.dot && !flags.minus;
    spec.plus_sign       = flags.plus;
    spec.space_sign      = flags.space && !flags.plus;
    spec.has_precision   = flags.dot;
    spec.field_width     = width_ext[pps_pkg::FIELD_BITS-1:0];
    spec.precision_value = prec_ext[pps_pkg::FIELD_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- tb/sv/printf_spec_parser_test.sv -----
// Self-checking testbench for the printf format specifier parser.
module printf_spec_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BITS = pps_pkg::NUMBER_BITS_DEFAULT;
  localparam int FIELD_W = pps_pkg::FIELD_BITS;
  localparam int SPEC_BYTES = 800;

  // Mirrors the parser: it holds its own copy of the flags and accumulators
  // and queues the specifier that each type letter or NUL byte must produce.
  class spec_scoreboard;
    bit alt, dot, minus, zero, plus, space, in_run;
    logic [NUM_BITS-1:0] width_acc, prec_acc;
    pps_pkg::spec_t pending_specs[$];
    int errors;
    int specs_checked;
    int specs_cut_short;

    function new();
      errors = 0;
      specs_checked = 0;
      specs_cut_short = 0;
      clear_state();
    endfunction

    function void clear_state();
      {alt, dot, minus, zero, plus, space, in_run} = '0;
      width_acc = '0;
      prec_acc = '0;
    endfunction

    // Zero-pad loses to a dot or a minus, and space loses to plus.
    function pps_pkg::spec_t resolve(pps_pkg::type_code_t code, bit early);
      pps_pkg::spec_t s;
      s.type_code       = code;
      s.ended_early     = early;
      s.alt_form        = alt;
      s.left_justify    = minus;
      s.zero_pad        = zero && !dot && !minus;
      s.plus_sign       = plus;
      s.space_sign      = space && !plus;
      s.has_precision   = dot;
      s.field_width     = FIELD_W'(width_acc);
      s.precision_value = FIELD_W'(prec_acc);
      return s;
    endfunction

    // Advances the model by one accepted byte.
    function void predict_spec(logic [7:0] c);
      pps_pkg::type_code_t code;
      bit is_type;
      bit was_run;
      longint unsigned num;
      longint unsigned num_max;
      num_max = (64'd1 << NUM_BITS) - 1;
      is_type = 1'b1;
      code = pps_pkg::TYPE_C;
      case (c)
        "c":     code = pps_pkg::TYPE_C;
        "s":     code = pps_pkg::TYPE_S;
        "p":     code = pps_pkg::TYPE_P;
        "d":     code = pps_pkg::TYPE_D;
        "i":     code = pps_pkg::TYPE_I;
        "u":     code = pps_pkg::TYPE_U;
        "x":     code = pps_pkg::TYPE_X_LOWER;
        "X":     code = pps_pkg::TYPE_X_UPPER;
        "%":     code = pps_pkg::TYPE_PCT;
        default: is_type = 1'b0;
      endcase
      if (c == pps_pkg::CHAR_NUL || is_type) begin
        pending_specs.push_back(resolve(code, c == pps_pkg::CHAR_NUL));
        clear_state();
        return;
      end
      was_run = in_run;
      in_run = 1'b0;
      // A zero opens a number only after a dot or minus, or inside a run.
      if (c >= pps_pkg::CHAR_ZERO && c <= pps_pkg::CHAR_NINE &&
          (was_run || c != pps_pkg::CHAR_ZERO || dot || minus)) begin
        num = c - pps_pkg::CHAR_ZERO;
        if (was_run) num = num + 10 * (dot ? prec_acc : width_acc);
        if (num > num_max) num = num_max;
        if (dot) prec_acc = NUM_BITS'(num);
        else width_acc = NUM_BITS'(num);
        in_run = 1'b1;
      end else begin
        case (c)
          pps_pkg::CHAR_HASH:  alt = 1'b1;
          pps_pkg::CHAR_DOT:   dot = 1'b1;
          pps_pkg::CHAR_MINUS: minus = 1'b1;
          pps_pkg::CHAR_ZERO:  zero = 1'b1;
          pps_pkg::CHAR_PLUS:  plus = 1'b1;
          pps_pkg::CHAR_SPACE: if (!plus) space = 1'b1;
          default: ;
        endcase
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_spec(pps_pkg::spec_t got);
      pps_pkg::spec_t want;
      if (pending_specs.size() == 0) begin
        $error("result transfer with no specifier pending");
        errors++;
        return;
      end
      want = pending_specs.pop_front();
      specs_checked++;
      if (want.ended_early) specs_cut_short++;
      compare("type_code", want.type_code, got.type_code);
      compare("ended_early", want.ended_early, got.ended_early);
      compare("alt_form", want.alt_form, got.alt_form);
      compare("left_justify", want.left_justify, got.left_justify);
      compare("zero_pad", want.zero_pad, got.zero_pad);
      compare("plus_sign", want.plus_sign, got.plus_sign);
      compare("space_sign", want.space_sign, got.space_sign);
      compare("has_precision", want.has_precision, got.has_precision);
      compare("field_width", want.field_width, got.field_width);
      compare("precision_value", want.precision_value, got.precision_value);
    endfunction

    function int waiting();
      return pending_specs.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [4:0]  m_tuser;

  spec_scoreboard sb = new();
  int bytes_sent = 0;

  printf_spec_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths for both sides: mostly none or a few cycles, now and then a
  // long pause so that stalls land on every stage of the pipeline.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte and returns at the edge where the transfer happens.
  // Valid stays high from one byte to the next when there is no gap, so the
  // signal never sees two assignments in one time step.
  task automatic send_char(logic [7:0] c, bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i], 1'b0);
  endtask

  // All handshakes are sampled at the rising edge, before any nonblocking
  // update of that edge lands, so each process sees the pre-edge values.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.predict_spec(s_tdata);
  end

  // The result fields sit in m_tuser and m_tdata in the same order as the
  // package's spec_t, lowest field first, so a plain concatenation unpacks them.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_spec(pps_pkg::spec_t'({m_tdata[37:0], m_tuser}));
  end

  // Receiver: short ready runs broken by stalls, with the occasional long
  // stretch of steady readiness.
  initial begin
    int run;
    int stall;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int tokens;
    int len;
    bit calm;
    bit nines;
    string flag_chars;
    string type_chars;
    flag_chars = "#-0+ ";
    type_chars = "cspdiuxX%";
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first spec sets zero-pad, sets space before plus so
    // that plus must clear it, and has a zero inside the width run. The second
    // has a zero after minus that starts a number, and a precision run that
    // saturates. Then come the byte extremes, a NUL that ends a spec early,
    // and each remaining type letter on an empty spec.
    send_text("0 +#70d");
    send_text("-0.99999x");
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(pps_pkg::CHAR_NUL, 1'b0);
    send_text("cspiuX%");

    // Random part: mostly well-formed specs of flags, digit runs and dots in
    // random order, closed by a type letter or now and then a NUL; the rest is
    // noise. Every byte counts toward the total.
    while (bytes_sent < SPEC_BYTES) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), calm);
      end else begin
        tokens = $urandom_range(0, 6);
        repeat (tokens) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              send_char(flag_chars[$urandom_range(0, 4)], calm);
            end
            4, 5, 6: begin
              // Long runs of nines push the accumulator into saturation.
              len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
              nines = ($urandom_range(0, 3) == 0);
              repeat (len) begin
                send_char(8'(pps_pkg::CHAR_ZERO + (nines ? 9 : $urandom_range(0, 9))), calm);
              end
            end
            7, 8: begin
              send_char(pps_pkg::CHAR_DOT, calm);
            end
            default: send_char(8'($urandom_range(0, 255)), calm);
          endcase
        end
        if ($urandom_range(0, 11) == 0) send_char(pps_pkg::CHAR_NUL, calm);
        else send_char(type_chars[$urandom_range(0, 8)], calm);
      end
    end
    s_tvalid <= 1'b0;

    // Let the monitor record the last transfer, drain, then give the
    // two-stage pipeline time to show any stray result.
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d specifiers, %0d of them cut short by NUL.",
             bytes_sent, sb.specs_checked, sb.specs_cut_short);
    if (sb.errors == 0) begin
      $display("printf_spec_parser: match");
    end else begin
      $display("Found %0d field errors.", sb.errors);
      $display("printf_spec_parser: mismatch");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d specifiers outstanding.", sb.waiting());
    $display("printf_spec_parser: mismatch");
    $finish;
  end

endmodule
